@@ rtl/core/swr_pkg.sv @@
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants for the stop-and-wait receiver core.
// ----------------------------------------------------------------------------
package swr_pkg;

	localparam int unsigned WordsPerPacketDefault = 500;
	localparam int unsigned QueueDepthDefault     = 4;

	localparam logic [16:0] AckReject = 17'h1FFFF;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_SUM = 2'd1,
		ST_BAD_NUM = 2'd2,
		ST_DONE    = 2'd3
	} status_t;

	// One finished packet as seen by the checking stage
	typedef struct packed {
		logic [15:0] sum;
		logic [15:0] seq;
		logic [15:0] sent;
	} pkt_t;

	// Ones' complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

@@ rtl/core/swr_front.sv @@
// ----------------------------------------------------------------------------
// swr_front
// Accepts payload words, keeps the running checksum and word count, and
// pushes one packet record into the queue at each packet end.
// ----------------------------------------------------------------------------
module swr_front #(
	parameter int unsigned WORDS_PER_PACKET = swr_pkg::WordsPerPacketDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          accept,
	input  logic [15:0]   data_word,
	input  logic [15:0]   seq_number,
	input  logic [15:0]   sent_checksum,
	input  logic          last_word,
	output logic          push,
	output swr_pkg::pkt_t push_pkt
);
	import swr_pkg::*;

	localparam int unsigned CntW = (WORDS_PER_PACKET > 1) ? $clog2(WORDS_PER_PACKET) : 1;
	localparam logic [CntW-1:0] CntLast = CntW'(WORDS_PER_PACKET - 1);

	logic [15:0]     sum_q;
	logic [CntW-1:0] cnt_q;
	logic [15:0]     sum_next;
	logic            pkt_end;

	assign sum_next = oc_add(sum_q, data_word);
	assign pkt_end  = last_word || (cnt_q == CntLast);

	assign push          = accept && pkt_end && !clear;
	assign push_pkt.sum  = ~sum_next;
	assign push_pkt.seq  = seq_number;
	assign push_pkt.sent = sent_checksum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (clear) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (pkt_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (cnt_q == '0) && (sum_q == '0))
		else $error("word count not restarted after packet end");
`endif

endmodule

@@ rtl/core/swr_queue.sv @@
// ----------------------------------------------------------------------------
// swr_queue
// Short register queue of finished packets between the front and back parts.
// ----------------------------------------------------------------------------
module swr_queue #(
	parameter int unsigned DEPTH = swr_pkg::QueueDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swr_pkg::pkt_t push_pkt,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output swr_pkg::pkt_t head_pkt
);
	import swr_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	pkt_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full      = (cnt_q == CntFull);
	assign not_empty = (cnt_q != '0);
	assign head_pkt  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("request pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
`endif

endmodule

@@ rtl/core/swr_back.sv @@
// ----------------------------------------------------------------------------
// swr_back
// Checks each finished packet against the expected sequence number and the
// checksum, advances the expected count and holds the acknowledgement.
// ----------------------------------------------------------------------------
module swr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_total,
	input  logic               pkt_valid,
	input  swr_pkg::pkt_t      pkt,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] ack_number,
	output logic [1:0]         status,
	output logic               transfer_done
);
	import swr_pkg::*;

	logic [15:0] total_q;
	logic [15:0] expected_q;
	logic        out_valid_q;
	logic [16:0] ack_q;
	status_t     status_q;
	logic        done_q;

	status_t     st;
	logic [15:0] expected_next;

	assign pop = pkt_valid && (!out_valid_q || out_ready);

	always_comb begin
		priority if (expected_q >= total_q) begin
			st = ST_DONE;
		end else if (pkt.seq != expected_q) begin
			st = ST_BAD_NUM;
		end else if (pkt.sum != pkt.sent) begin
			st = ST_BAD_SUM;
		end else begin
			st = ST_OK;
		end
	end

	assign expected_next = (st == ST_OK) ? expected_q + 16'd1 : expected_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			expected_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_we) begin
			total_q    <= cfg_total;
			expected_q <= '0;
		end else begin
			if (pop) begin
				expected_q  <= expected_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ack_q    <= (st == ST_OK) ? {1'b0, pkt.seq} : AckReject;
			status_q <= st;
			done_q   <= (expected_next >= total_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign ack_number    = signed'(ack_q);
	assign status        = status_q;
	assign transfer_done = done_q;

`ifndef ASSERT_OFF
	a_advance_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !cfg_we && st == ST_OK) |=> (expected_q == $past(expected_q) + 16'd1))
		else $error("expected number did not advance on accepted packet");
	a_done_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !cfg_we && st == ST_DONE) |=> (ack_q == AckReject) && done_q)
		else $error("completed transfer not reported as done");
`endif

endmodule

@@ rtl/core/stop_and_wait_receiver_core.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_receiver_core
// Stop-and-wait receiver: ones' complement checksum, sequence check, acks.
// ----------------------------------------------------------------------------
// Takes one payload word per cycle and gives one acknowledgement per packet.
// The record of a finished packet is written into the queue, and out_valid
// is registered in the back part. The front part sums words with end-around
// carry and hands each finished packet to a short queue; the back part checks
// number and checksum one packet per cycle while acknowledgements are taken.
// Input stalls only when QUEUE_DEPTH finished packets wait behind an unaccepted
// acknowledgement. A write to total_packets restarts the transfer and must be
// issued while the block is idle.
module stop_and_wait_receiver_core #(
	parameter int unsigned WORDS_PER_PACKET = swr_pkg::WordsPerPacketDefault,
	parameter int unsigned QUEUE_DEPTH      = swr_pkg::QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               total_packets_we,
	input  logic [15:0]        total_packets,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        data_word,
	input  logic [15:0]        seq_number,
	input  logic [15:0]        sent_checksum,
	input  logic               last_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] ack_number,
	output logic [1:0]         status,
	output logic               transfer_done
);
	import swr_pkg::*;

	logic accept;
	logic push;
	pkt_t push_pkt;
	logic pop;
	logic q_full;
	logic q_not_empty;
	pkt_t head_pkt;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	swr_front #(
		.WORDS_PER_PACKET(WORDS_PER_PACKET)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (total_packets_we),
		.accept       (accept),
		.data_word    (data_word),
		.seq_number   (seq_number),
		.sent_checksum(sent_checksum),
		.last_word    (last_word),
		.push         (push),
		.push_pkt     (push_pkt)
	);

	swr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.pop      (pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.head_pkt (head_pkt)
	);

	swr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (total_packets_we),
		.cfg_total    (total_packets),
		.pkt_valid    (q_not_empty),
		.pkt          (head_pkt),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ack_number   (ack_number),
		.status       (status),
		.transfer_done(transfer_done)
	);

endmodule

@@ test/stop_and_wait_receiver_core_test.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_receiver_core_test
// Self-checking bench for the stop-and-wait receiver core.
// ----------------------------------------------------------------------------
// Payload words go in over a valid/ready request channel and acknowledgements
// come back over another. A predictor in the bench keeps its own copy of the
// running sum, word count, expected number and packet total, and queues one
// expected acknowledgement for each packet end. Each acknowledgement is
// checked field by field against the oldest one queued. Directed packets
// cover every status, error priority, the word-count limit and a zero total.
// A long hold-off on the acknowledgement side fills the core and stalls its
// input; random traffic then runs under several idle and stall mixes.
// ----------------------------------------------------------------------------
module stop_and_wait_receiver_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import swr_pkg::*;

	localparam int unsigned WordsPerPacket = WordsPerPacketDefault;

	typedef enum int {
		FILL_MIXED,
		FILL_ONES,
		FILL_ZEROS
	} fill_t;

	typedef struct packed {
		logic [16:0] number;
		status_t     stat;
		logic        done;
	} ack_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               total_packets_we;
	logic [15:0]        total_packets;
	logic               in_valid;
	logic               in_ready;
	logic [15:0]        data_word;
	logic [15:0]        seq_number;
	logic [15:0]        sent_checksum;
	logic               last_word;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [16:0] ack_number;
	logic [1:0]         status;
	logic               transfer_done;

	// Predictor state
	logic [15:0] pkt_total;
	logic [15:0] next_seq;
	logic [15:0] sum_acc;
	int          word_cnt;
	ack_t        pending_acks[$];

	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_left;
	int words_sent;
	int acks_seen;
	int input_stalls;
	int mismatches;
	int status_hits[4];

	stop_and_wait_receiver_core #(
		.WORDS_PER_PACKET(WordsPerPacket)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.total_packets_we(total_packets_we),
		.total_packets   (total_packets),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_word       (data_word),
		.seq_number      (seq_number),
		.sent_checksum   (sent_checksum),
		.last_word       (last_word),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ack_number      (ack_number),
		.status          (status),
		.transfer_done   (transfer_done)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	// One accepted word: fold it in, and queue an ack if the packet ends here
	task automatic account_word(input logic [15:0] w, input logic [15:0] s,
			input logic [15:0] c, input logic l);
		ack_t        a;
		logic [15:0] folded;
		sum_acc = ones_add(sum_acc, w);
		word_cnt++;
		if (!l && word_cnt < WordsPerPacket)
			return;
		folded   = ~sum_acc;
		sum_acc  = '0;
		word_cnt = 0;
		a.number = AckReject;
		if (next_seq >= pkt_total) begin
			a.stat = ST_DONE;
		end else if (s != next_seq) begin
			a.stat = ST_BAD_NUM;
		end else if (folded != c) begin
			a.stat = ST_BAD_SUM;
		end else begin
			a.stat   = ST_OK;
			a.number = {1'b0, s};
			next_seq = next_seq + 16'd1;
		end
		a.done = (next_seq >= pkt_total);
		pending_acks.push_back(a);
	endtask

	task automatic report_mismatch(input string what, input logic [16:0] got,
			input logic [16:0] want);
		$display("%t MISMATCH %s: got %h, want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Entered and left at a falling edge; valid is left high for the caller
	task automatic send_word(input logic [15:0] w, input logic [15:0] s,
			input logic [15:0] c, input logic l);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		data_word     <= w;
		seq_number    <= s;
		sent_checksum <= c;
		last_word     <= l;
		@(posedge clk);
		while (!in_ready) begin
			input_stalls++;
			@(posedge clk);
		end
		account_word(w, s, c, l);
		words_sent++;
		@(negedge clk);
	endtask

	// Number and checksum are only sampled on the closing word, so the
	// others carry random values there
	task automatic send_packet(input int len, input bit good_seq, input bit good_sum,
			input bit mark_last, input fill_t fill);
		logic [15:0] words[$];
		logic [15:0] acc;
		logic [15:0] seq;
		logic [15:0] chk;
		logic [15:0] w;
		acc = sum_acc;
		for (int i = 0; i < len; i++) begin
			case (fill)
			FILL_ONES: begin
				w = 16'hFFFF;
			end
			FILL_ZEROS: begin
				w = 16'h0000;
			end
			default: begin
				case ($urandom_range(9))
				0:       w = 16'h0000;
				1:       w = 16'hFFFF;
				default: w = 16'($urandom);
				endcase
			end
			endcase
			words.push_back(w);
			acc = ones_add(acc, w);
		end
		seq = good_seq ? next_seq : next_seq ^ 16'($urandom_range(1, 16'hFFFF));
		chk = good_sum ? ~acc : ~acc ^ 16'($urandom_range(1, 16'hFFFF));
		for (int i = 0; i < len; i++) begin
			if (i == len - 1)
				send_word(words[i], seq, chk, mark_last);
			else
				send_word(words[i], 16'($urandom), 16'($urandom), 1'b0);
		end
	endtask

	// Only while idle; a short pause lets a partial packet settle in the core
	task automatic write_total(input logic [15:0] v);
		in_valid <= 1'b0;
		while (pending_acks.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		total_packets_we <= 1'b1;
		total_packets    <= v;
		@(posedge clk);
		pkt_total = v;
		next_seq  = '0;
		sum_acc   = '0;
		word_cnt  = 0;
		@(negedge clk);
		total_packets_we <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		ack_t want;
		if (arst_n && out_valid && out_ready) begin
			acks_seen++;
			if (pending_acks.size() == 0) begin
				report_mismatch("unexpected ack", ack_number, '0);
			end else begin
				want = pending_acks.pop_front();
				status_hits[want.stat]++;
				if (ack_number !== want.number)
					report_mismatch("ack_number", ack_number, want.number);
				if (status !== want.stat)
					report_mismatch("status", {15'd0, status}, {15'd0, want.stat});
				if (transfer_done !== want.done)
					report_mismatch("transfer_done", {16'd0, transfer_done},
						{16'd0, want.done});
			end
		end
	end

	// Total still at its reset value of zero: everything reports complete
	task automatic test_power_on_total();
		send_packet(1, 1'b1, 1'b1, 1'b1, FILL_MIXED);
		send_packet(3, 1'b1, 1'b1, 1'b1, FILL_ONES);
	endtask

	task automatic test_packet_outcomes();
		write_total(16'd3);
		send_packet(3, 1'b1, 1'b1, 1'b1, FILL_ONES);
		send_packet(1, 1'b0, 1'b1, 1'b1, FILL_MIXED);
		// wrong number wins over a bad checksum
		send_packet(2, 1'b0, 1'b0, 1'b1, FILL_MIXED);
		send_packet(2, 1'b1, 1'b0, 1'b1, FILL_ZEROS);
		send_word(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
		send_packet(4, 1'b1, 1'b1, 1'b1, FILL_MIXED);
		send_packet(1, 1'b1, 1'b1, 1'b1, FILL_ZEROS);
		send_packet(2, 1'b1, 1'b1, 1'b1, FILL_MIXED);
		send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		write_total(16'd0);
		send_packet(1, 1'b1, 1'b1, 1'b1, FILL_MIXED);
	endtask

	// Packet closed by the word count alone, then a fresh one-word packet
	task automatic test_word_limit();
		write_total(16'd2);
		send_packet(WordsPerPacket, 1'b1, 1'b1, 1'b0, FILL_MIXED);
		send_packet(1, 1'b1, 1'b1, 1'b1, FILL_ONES);
	endtask

	task automatic test_input_backpressure();
		write_total(16'd40);
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		repeat (12)
			send_packet(1, 1'b1, 1'b1, 1'b1, FILL_MIXED);
	endtask

	task automatic test_random_traffic();
		int          idle_mix[4];
		int          stall_mix[4];
		logic [15:0] totals[4];
		int          phase_end;
		int          len;
		idle_mix  = '{0, 83, 0, 17};
		stall_mix = '{0, 0, 83, 17};
		totals    = '{16'hFFFF, 16'd10, 16'($urandom_range(3, 30)), 16'd20};
		for (int p = 0; p < 4; p++) begin
			write_total(totals[p]);
			sender_idle_pct    = idle_mix[p];
			receiver_stall_pct = stall_mix[p];
			phase_end          = words_sent + 16;
			while (words_sent < phase_end) begin
				if ($urandom_range(99) < 6) begin
					// stray fragment that runs into the next packet
					send_packet($urandom_range(1, 3), 1'b0, 1'b0, 1'b0, FILL_MIXED);
				end else begin
					len = ($urandom_range(15) == 0) ? $urandom_range(9, 20)
						: $urandom_range(1, 6);
					send_packet(len, $urandom_range(9) != 0, $urandom_range(9) != 0,
						1'b1, FILL_MIXED);
				end
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		total_packets_we   = 1'b0;
		total_packets      = '0;
		in_valid           = 1'b0;
		data_word          = '0;
		seq_number         = '0;
		sent_checksum      = '0;
		last_word          = 1'b0;
		pkt_total          = '0;
		next_seq           = '0;
		sum_acc            = '0;
		word_cnt           = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_left          = 0;
		words_sent         = 0;
		acks_seen          = 0;
		input_stalls       = 0;
		mismatches         = 0;
		status_hits        = '{0, 0, 0, 0};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_power_on_total();
		test_packet_outcomes();
		test_word_limit();
		test_input_backpressure();
		test_random_traffic();

		in_valid <= 1'b0;
		while (pending_acks.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d words, %0d acks: ok %0d, bad sum %0d, bad number %0d, complete %0d",
			words_sent, acks_seen, status_hits[ST_OK], status_hits[ST_BAD_SUM],
			status_hits[ST_BAD_NUM], status_hits[ST_DONE]);
		$display("input request stalled %0d cycles; %0d mismatches logged",
			input_stalls, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ stop_and_wait_receiver_core.f @@
rtl/core/swr_pkg.sv
rtl/core/swr_front.sv
rtl/core/swr_queue.sv
rtl/core/swr_back.sv
rtl/core/stop_and_wait_receiver_core.sv
test/stop_and_wait_receiver_core_test.sv
